/* hw/rtl/sld_pkg.sv */
`timescale 1ns / 1ps
// sld_pkg: types and constants for the sync/length packet deframer
// no dependencies

package sld_pkg;

	typedef enum logic [1:0] {
		PH_HUNT      = 2'd0,
		PH_GOT_FIRST = 2'd1,
		PH_LENGTH    = 2'd2,
		PH_PAYLOAD   = 2'd3
	} phase_t;

	typedef enum logic {
		KIND_START   = 1'b0,
		KIND_PAYLOAD = 1'b1
	} kind_t;

	typedef enum logic {
		REG_SYNC_FIRST  = 1'b0,
		REG_SYNC_SECOND = 1'b1
	} reg_idx_t;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'h21;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h22;

endpackage

/* hw/rtl/sync_length_packet_deframer.sv */
`timescale 1ns / 1ps
// sync_length_packet_deframer: byte-wide sync-word hunt, length capture and payload framing
// depends on sld_pkg

// Takes one byte per clock while the input is not stalled. Each byte is
// held in an input register; the phase machine then decides whether it
// yields a result, which is held in an output register, so each result
// passes through the input register and then the output register. A byte
// that yields no result is dropped without waiting for the output side. The
// input stalls only while the output register holds an untaken result and
// the input register holds a byte that yields a result. Sync bytes are
// programmable through the config port (index 0 first, index 1 second);
// config writes are always ready and should be made while idle.
module sync_length_packet_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] in_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       kind,
	output logic [7:0] value,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);
	import sld_pkg::*;

	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;
	phase_t     phase_q;
	phase_t     phase_d;
	logic [7:0] remaining_q;
	logic [7:0] remaining_d;

	logic       valid_s1;
	logic [7:0] byte_s1;

	logic       emit;
	logic       res_kind;
	logic       res_last;
	logic       advance;
	logic       out_free;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				REG_SYNC_SECOND: sync_second_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	assign out_free  = !res_valid || !res_stall;
	assign advance   = valid_s1 && (!emit || out_free);
	assign src_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			byte_s1 <= in_byte;
		end
	end

	// next state
	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		case (phase_q)
			PH_HUNT: begin
				phase_d = (byte_s1 == sync_first_q) ? PH_GOT_FIRST : PH_HUNT;
			end
			PH_GOT_FIRST: begin
				if (byte_s1 == sync_second_q) begin
					phase_d = PH_LENGTH;
				end else if (byte_s1 == sync_first_q) begin
					phase_d = PH_GOT_FIRST;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_LENGTH: begin
				remaining_d = byte_s1;
				phase_d     = (byte_s1 == 8'd0) ? PH_HUNT : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				if (remaining_q <= 8'd1) begin
					remaining_d = 8'd0;
					phase_d     = PH_HUNT;
				end else begin
					remaining_d = remaining_q - 8'd1;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// outputs
	always_comb begin
		emit     = 1'b0;
		res_kind = KIND_START;
		res_last = 1'b0;
		case (phase_q)
			PH_HUNT, PH_GOT_FIRST: begin
				emit = 1'b0;
			end
			PH_LENGTH: begin
				emit     = 1'b1;
				res_kind = KIND_START;
				res_last = (byte_s1 == 8'd0);
			end
			PH_PAYLOAD: begin
				emit     = 1'b1;
				res_kind = KIND_PAYLOAD;
				res_last = (remaining_q <= 8'd1);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			remaining_q <= 8'd0;
		end else if (advance) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (out_free) begin
			res_valid <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && emit) begin
			kind  <= res_kind;
			value <= byte_s1;
			last  <= res_last;
		end
	end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: randomized regression for sync_length_packet_deframer with a byte-level predictor
// depends on sld_pkg and sync_length_packet_deframer

module tb_top;
	import sld_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 120;
	localparam int SETTLE_CYCLES = 6;
	localparam int BYTES_PER_SETTING = 130;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} frame_res_t;

	class deframe_scoreboard;
		phase_t     phase;
		logic [7:0] remaining;
		logic [7:0] sync_a;
		logic [7:0] sync_b;
		frame_res_t expected_q[$];
		int         errors;

		function new();
			phase = PH_HUNT;
			remaining = 8'd0;
			sync_a = SYNC_FIRST_RST;
			sync_b = SYNC_SECOND_RST;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [7:0] data);
			if (idx == REG_SYNC_FIRST) begin
				sync_a = data;
			end else begin
				sync_b = data;
			end
		endfunction

		// advance the framing state by one accepted byte
		function void note_byte(logic [7:0] b);
			frame_res_t r;
			case (phase)
				PH_HUNT: begin
					phase = (b == sync_a) ? PH_GOT_FIRST : PH_HUNT;
				end
				PH_GOT_FIRST: begin
					if (b == sync_b) begin
						phase = PH_LENGTH;
					end else if (b == sync_a) begin
						phase = PH_GOT_FIRST;
					end else begin
						phase = PH_HUNT;
					end
				end
				PH_LENGTH: begin
					r.kind = KIND_START;
					r.value = b;
					r.last = (b == 8'd0);
					expected_q.push_back(r);
					remaining = b;
					phase = (b == 8'd0) ? PH_HUNT : PH_PAYLOAD;
				end
				default: begin
					r.kind = KIND_PAYLOAD;
					r.value = b;
					r.last = (remaining <= 8'd1);
					expected_q.push_back(r);
					if (remaining <= 8'd1) begin
						remaining = 8'd0;
						phase = PH_HUNT;
					end else begin
						remaining = remaining - 8'd1;
					end
				end
			endcase
		endfunction

		function void check_result(logic k, logic [7:0] v, logic l);
			frame_res_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result kind=%0b value=%02h last=%0b",
					$time, k, v, l);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (k !== e.kind) begin
				$display("%0t: kind mismatch expected %0b actual %0b", $time, e.kind, k);
				errors++;
			end
			if (v !== e.value) begin
				$display("%0t: value mismatch expected %02h actual %02h", $time, e.value, v);
				errors++;
			end
			if (l !== e.last) begin
				$display("%0t: last mismatch expected %0b actual %0b", $time, e.last, l);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       src_valid;
	logic       src_stall;
	logic [7:0] in_byte;
	logic       res_valid;
	logic       res_stall;
	logic       kind;
	logic [7:0] value;
	logic       last;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_index;
	logic [7:0] cfg_data;

	deframe_scoreboard sb;
	int   cycle_cnt;
	int   sent_cnt;
	int   src_idle_pct;
	int   rcv_idle_pct;
	logic hold_on;

	sync_length_packet_deframer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.in_byte(in_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.kind(kind),
		.value(value),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("sync_length_packet_deframer regression: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		res_stall <= hold_on || ($urandom_range(99) < rcv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			sb.check_result(kind, value, last);
		end
	end

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		sb.note_byte(b);
		sent_cnt++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		src_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_cfg(input reg_idx_t idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	function automatic logic [7:0] payload_byte();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10) return sb.sync_a;
		if (pick < 20) return sb.sync_b;
		return 8'($urandom);
	endfunction

	task automatic send_packet(input int len);
		int n;
		n = $urandom_range(3);
		repeat (n) send_byte(8'($urandom));
		if ($urandom_range(99) < 12) begin
			// broken request: first sync byte followed by junk
			send_byte(sb.sync_a);
			send_byte(8'($urandom));
			return;
		end
		if ($urandom_range(99) < 15) send_byte(sb.sync_a);
		send_byte(sb.sync_a);
		send_byte(sb.sync_b);
		send_byte(8'(len));
		repeat (len) send_byte(payload_byte());
	endtask

	function automatic int pick_length();
		if ($urandom_range(99) < 3) return $urandom_range(255, 64);
		return $urandom_range(10);
	endfunction

	logic [7:0] directed_bytes[] = '{
		8'h00, 8'hFF, 8'h21, 8'h21, 8'h22, 8'h00,
		8'h21, 8'h22, 8'h03, 8'h21, 8'h22, 8'hFF,
		8'h21, 8'h05, 8'h22, 8'h21, 8'h22, 8'h01, 8'h80,
		8'h21, 8'h22, 8'h02, 8'h7F, 8'h22
	};

	logic [7:0] sync_pairs[6][2] = '{
		'{8'h21, 8'h22}, '{8'h00, 8'hFF}, '{8'hFF, 8'h00},
		'{8'hAA, 8'hAA}, '{8'h00, 8'h00}, '{8'h5C, 8'hC3}
	};

	initial begin
		int target;
		sb = new();
		cycle_cnt = 0;
		sent_cnt = 0;
		src_idle_pct = 9;
		rcv_idle_pct = 48;
		hold_on = 1'b0;
		arst_n = 1'b0;
		src_valid = 1'b0;
		in_byte = 8'd0;
		res_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SYNC_FIRST;
		cfg_data = 8'd0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
		wait_drained();

		for (int s = 0; s < 6; s++) begin
			if (s == 5) begin
				sync_pairs[s][0] = 8'($urandom);
				sync_pairs[s][1] = 8'($urandom);
			end
			write_cfg(REG_SYNC_FIRST, sync_pairs[s][0]);
			write_cfg(REG_SYNC_SECOND, sync_pairs[s][1]);
			cfg_valid <= 1'b0;
			@(negedge clk);
			if (s < 2) begin
				src_idle_pct = 9;
				rcv_idle_pct = 48;
			end else if (s < 4) begin
				src_idle_pct = 48;
				rcv_idle_pct = 9;
			end else begin
				src_idle_pct = 0;
				rcv_idle_pct = 0;
			end

			if (s == 0) begin
				// long output hold while the source keeps pushing
				fork
					begin
						@(posedge clk);
						hold_on <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_on <= 1'b0;
					end
				join_none
				src_idle_pct = 0;
				repeat (8) send_packet(6);
				src_idle_pct = 9;
			end
			if (s == 4) send_packet(255);

			target = sent_cnt + BYTES_PER_SETTING;
			while (sent_cnt < target) send_packet(pick_length());
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("sync_length_packet_deframer regression: pass");
		end else begin
			$display("sync_length_packet_deframer regression: fail");
		end
		$finish;
	end

endmodule
